FILE: design/vtpd_pkg.sv
// Shared types and constants for the vertex transform with perspective divide.
package vtpd_pkg;

   // Signed Q16.16 component.
   typedef logic signed [31:0] q_type;

   // One vertex and one 4x4 coefficient matrix, index [row][col].
   typedef q_type [3:0] vec_type;
   typedef q_type [3:0][3:0] mat_type;

   // Configuration register file.
   localparam int NumRegs    = 8;
   localparam int RegWidth   = 64;
   localparam int IndexWidth = 8;

   // Quotient bits resolved by the divider, one per pipeline stage.
   localparam int DivSteps = 48;

   // Identity matrix register values.
   localparam logic [RegWidth-1:0] RegOneLow  = 64'h0000_0000_0001_0000;
   localparam logic [RegWidth-1:0] RegOneHigh = 64'h0001_0000_0000_0000;

endpackage

FILE: design/vtpd_req_if.sv
// Input channel carrying one homogeneous vertex per transfer.
interface vtpd_req_if;
   logic                valid;
   logic                ready;
   vtpd_pkg::q_type     vec_x;
   vtpd_pkg::q_type     vec_y;
   vtpd_pkg::q_type     vec_z;
   vtpd_pkg::q_type     vec_w;

   modport source (output valid, output vec_x, output vec_y, output vec_z, output vec_w,
                   input ready);
   modport sink (input valid, input vec_x, input vec_y, input vec_z, input vec_w,
                 output ready);
endinterface

FILE: design/vtpd_rsp_if.sv
// Result channel carrying one transformed vertex per transfer.
interface vtpd_rsp_if;
   logic                valid;
   logic                ready;
   vtpd_pkg::q_type     out_x;
   vtpd_pkg::q_type     out_y;
   vtpd_pkg::q_type     out_z;
   vtpd_pkg::q_type     out_w;
   logic                divided;
   logic                overflow;

   modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                   output divided, output overflow, input ready);
   modport sink (input valid, input out_x, input out_y, input out_z, input out_w,
                 input divided, input overflow, output ready);
endinterface

FILE: design/vtpd_matmul.sv
// Two-stage matrix-vector multiply: registered products, then row sums with saturation.
module vtpd_matmul (
   input  logic              clock,
   input  logic              advance,
   input  vtpd_pkg::vec_type vec,
   input  vtpd_pkg::mat_type mat,
   output vtpd_pkg::vec_type rows,
   output logic              ovf
);

   logic signed [63:0] prod_ff [4][4];
   logic signed [63:0] prod_in [4][4];
   vtpd_pkg::vec_type  rows_ff, rows_in;
   logic               ovf_ff, ovf_in;

   // First stage: sixteen independent 32x32 products.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            prod_in[r][c] = 64'(mat[r][c]) * 64'(vec[c]);
         end
      end
   end

   // Second stage: exact row sum, floor to Q16.16 and saturate.
   always_comb begin
      logic signed [65:0] sum;
      logic signed [49:0] shifted;
      ovf_in = 1'b0;
      for (int r = 0; r < 4; r++) begin
         sum = 66'(prod_ff[r][0]) + 66'(prod_ff[r][1]) + 66'(prod_ff[r][2])
             + 66'(prod_ff[r][3]);
         shifted = sum[65:16];
         if (shifted > 50'sh7FFF_FFFF) begin
            rows_in[r] = 32'sh7FFF_FFFF;
            ovf_in = 1'b1;
         end else if (shifted < -50'sh8000_0000) begin
            rows_in[r] = 32'sh8000_0000;
            ovf_in = 1'b1;
         end else begin
            rows_in[r] = shifted[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         rows_ff <= rows_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign rows = rows_ff;
   assign ovf  = ovf_ff;

endmodule

FILE: design/vtpd_div_lane.sv
// Pipelined signed divide (value * 65536) / divisor, one quotient bit per stage.
module vtpd_div_lane (
   input  logic            clock,
   input  logic            advance,
   input  vtpd_pkg::q_type dividend,
   input  vtpd_pkg::q_type divisor,
   output vtpd_pkg::q_type result,
   output logic            ovf
);

   typedef struct packed {
      logic [47:0]     num;
      logic [31:0]     rem;
      logic [31:0]     den;
      logic            neg;
      logic            zero;
      vtpd_pkg::q_type orig;
   } lane_type;

   lane_type lane_ff [vtpd_pkg::DivSteps+1];
   lane_type lane_in [vtpd_pkg::DivSteps+1];

   // Prepare magnitudes and the sign of the quotient.
   always_comb begin
      logic [31:0] nmag;
      logic [31:0] dmag;
      nmag = dividend[31] ? (~dividend + 32'd1) : dividend;
      dmag = divisor[31] ? (~divisor + 32'd1) : divisor;
      lane_in[0].num  = {nmag, 16'd0};
      lane_in[0].rem  = '0;
      lane_in[0].den  = dmag;
      lane_in[0].neg  = dividend[31] ^ divisor[31];
      lane_in[0].zero = (divisor == '0);
      lane_in[0].orig = dividend;
   end

   // Restoring division steps.
   for (genvar s = 1; s <= vtpd_pkg::DivSteps; s++) begin : g_step
      always_comb begin
         logic [32:0] trial;
         logic [32:0] diff;
         logic        ge;
         trial = {lane_ff[s-1].rem, lane_ff[s-1].num[47]};
         diff  = trial - {1'b0, lane_ff[s-1].den};
         ge    = (trial >= {1'b0, lane_ff[s-1].den});
         lane_in[s]     = lane_ff[s-1];
         lane_in[s].rem = ge ? diff[31:0] : trial[31:0];
         lane_in[s].num = {lane_ff[s-1].num[46:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff <= lane_in;
      end
   end

   // Apply the sign and saturate; a zero divisor passes the value through.
   always_comb begin
      lane_type last;
      last = lane_ff[vtpd_pkg::DivSteps];
      ovf  = 1'b0;
      if (last.zero) begin
         result = last.orig;
      end else if (last.neg) begin
         if (last.num > 48'h8000_0000) begin
            result = 32'sh8000_0000;
            ovf    = 1'b1;
         end else begin
            result = ~last.num[31:0] + 32'd1;
         end
      end else begin
         if (last.num > 48'h7FFF_FFFF) begin
            result = 32'sh7FFF_FFFF;
            ovf    = 1'b1;
         end else begin
            result = last.num[31:0];
         end
      end
   end

endmodule

FILE: design/vertex_transform_perspective_divide.sv
// Vertex transform with perspective divide: a 4x4 Q16.16 matrix, held in eight
// 64-bit registers, multiplies each vertex; x, y and z are then divided by the
// transformed w when it is nonzero. The pipeline takes one vertex every cycle
// and each result passes through two stages for the products and row sums, 49
// for the divider (one quotient bit per stage over 48 bits plus setup) and the
// output register. Any stall on the result side holds the whole pipeline.
module vertex_transform_perspective_divide (
   input  logic                                 clock,
   input  logic                                 reset,
   vtpd_req_if.sink                             req_chan,
   vtpd_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [vtpd_pkg::IndexWidth-1:0]      csr_index,
   input  logic [vtpd_pkg::RegWidth-1:0]        csr_wdata
);

   localparam int LaneDepth = vtpd_pkg::DivSteps + 1;
   // Row stages and lane stages.
   localparam int Depth = 2 + LaneDepth;

   typedef struct packed {
      vtpd_pkg::q_type w;
      logic            divided;
      logic            ovf;
   } side_type;

   logic [vtpd_pkg::RegWidth-1:0] regs_ff [vtpd_pkg::NumRegs];
   vtpd_pkg::mat_type             mat;
   vtpd_pkg::vec_type             vec;
   vtpd_pkg::vec_type             rows;
   logic                          row_ovf;
   logic [Depth-1:0]              valid_ff;
   side_type                      side_ff [LaneDepth];
   vtpd_pkg::q_type               quot [3];
   logic [2:0]                    quot_ovf;
   logic                          advance;
   logic                          out_valid_ff;
   vtpd_pkg::q_type               out_ff [4];
   logic                          divided_ff, overflow_ff;

   // Configuration registers, reset to the identity matrix.
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[0] <= vtpd_pkg::RegOneLow;
         regs_ff[1] <= '0;
         regs_ff[2] <= vtpd_pkg::RegOneHigh;
         regs_ff[3] <= '0;
         regs_ff[4] <= '0;
         regs_ff[5] <= vtpd_pkg::RegOneLow;
         regs_ff[6] <= '0;
         regs_ff[7] <= vtpd_pkg::RegOneHigh;
      end else if (csr_we && (csr_index < vtpd_pkg::IndexWidth'(vtpd_pkg::NumRegs))) begin
         regs_ff[csr_index[2:0]] <= csr_wdata;
      end
   end

   // Unpack coefficients: even column low, odd column high.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         mat[r][0] = regs_ff[2*r][31:0];
         mat[r][1] = regs_ff[2*r][63:32];
         mat[r][2] = regs_ff[2*r+1][31:0];
         mat[r][3] = regs_ff[2*r+1][63:32];
      end
   end

   assign vec[0] = req_chan.vec_x;
   assign vec[1] = req_chan.vec_y;
   assign vec[2] = req_chan.vec_z;
   assign vec[3] = req_chan.vec_w;

   // The whole pipeline moves when the output slot is free or being taken.
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   vtpd_matmul u_matmul (
      .clock   (clock),
      .advance (advance),
      .vec     (vec),
      .mat     (mat),
      .rows    (rows),
      .ovf     (row_ovf)
   );

   for (genvar i = 0; i < 3; i++) begin : g_lane
      vtpd_div_lane u_lane (
         .clock    (clock),
         .advance  (advance),
         .dividend (rows[i]),
         .divisor  (rows[3]),
         .result   (quot[i]),
         .ovf      (quot_ovf[i])
      );
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[Depth-2:0], req_chan.valid};
         out_valid_ff <= valid_ff[Depth-1];
      end
   end

   // Sideband for w and flags alongside the divider lanes.
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0].w       <= rows[3];
         side_ff[0].divided <= (rows[3] != '0);
         side_ff[0].ovf     <= row_ovf;
         for (int s = 1; s < LaneDepth; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff[0]   <= quot[0];
         out_ff[1]   <= quot[1];
         out_ff[2]   <= quot[2];
         out_ff[3]   <= side_ff[LaneDepth-1].w;
         divided_ff  <= side_ff[LaneDepth-1].divided;
         overflow_ff <= side_ff[LaneDepth-1].ovf | (|quot_ovf);
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.out_x    = out_ff[0];
   assign rsp_chan.out_y    = out_ff[1];
   assign rsp_chan.out_z    = out_ff[2];
   assign rsp_chan.out_w    = out_ff[3];
   assign rsp_chan.divided  = divided_ff;
   assign rsp_chan.overflow = overflow_ff;

endmodule
